// ===== design/link_counter_replay_filter_assert.svh =====
// ----------------------------------------------------------------------------
// link_counter_replay_filter_assert.svh
// Assertion macros shared by the link counter replay filter RTL.
// ----------------------------------------------------------------------------
`ifndef LINK_COUNTER_REPLAY_FILTER_ASSERT_SVH
`define LINK_COUNTER_REPLAY_FILTER_ASSERT_SVH

// Check a consequence in the same cycle as its cause.
`define LCRF_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Check a consequence in the cycle after its cause.
`define LCRF_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== design/lcrf_pkg.sv =====
// ----------------------------------------------------------------------------
// lcrf_pkg
// Shared types and constants of the link counter replay filter.
// ----------------------------------------------------------------------------
package lcrf_pkg;

  localparam int unsigned CTR_W    = 32;
  localparam int unsigned LEN_W    = 8;
  localparam int unsigned IDX_W    = 4;
  localparam int unsigned WIN_W    = 6;
  localparam int unsigned TAG_W    = 5;
  localparam int unsigned CFG_IX_W = 8;
  localparam int unsigned CFG_D_W  = 8;

  typedef enum logic [1:0] {
    OP_INSTALL = 2'd0,
    OP_FORGET  = 2'd1,
    OP_TX      = 2'd2,
    OP_RX      = 2'd3
  } lcrf_op_e;

  typedef enum logic [2:0] {
    ST_OK      = 3'd0,
    ST_NO_KEY  = 3'd1,
    ST_BAD_LEN = 3'd2,
    ST_TOO_BIG = 3'd3,
    ST_AUTH    = 3'd4,
    ST_REPLAY  = 3'd5
  } lcrf_status_e;

  typedef enum logic [CFG_IX_W-1:0] {
    REG_REPLAY_WINDOW = 8'd0,
    REG_TAG_LENGTH    = 8'd1,
    REG_MAX_FRAME     = 8'd2,
    REG_MIN_SECURE    = 8'd3
  } lcrf_reg_e;

  typedef enum logic [1:0] {
    S_IDLE = 2'b01,
    S_EXEC = 2'b10
  } lcrf_state_e;

  // Decision of the execute unit for one transaction.
  typedef struct packed {
    lcrf_status_e       status;
    logic [CTR_W-1:0]   assigned;
    logic               kv_we;
    logic               kv_val;
    logic               ent_we;
    logic               inc_auth;
    logic               inc_replay;
  } lcrf_ctl_t;

endpackage

// ===== design/lcrf_state_mem.sv =====
// ----------------------------------------------------------------------------
// lcrf_state_mem
// Per-neighbour entry store: synchronous memory with registered read and
// per-entry written flags, so an untouched entry reads as zero.
// ----------------------------------------------------------------------------
module lcrf_state_mem #(
  parameter int unsigned DEPTH = 16,
  parameter int unsigned DW    = 96
) (
  input  logic                                    clk_i,
  input  logic                                    rst_ni,
  input  logic                                    rd_en_i,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr_i,
  output logic [DW-1:0]                           rd_data_o,
  input  logic                                    wr_en_i,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr_i,
  input  logic [DW-1:0]                           wr_data_i
);

  logic [DW-1:0]    mem [DEPTH];
  logic [DEPTH-1:0] written_q;
  logic [DW-1:0]    rd_data_q;
  logic             rd_written_q;

  // Write port and registered read port
  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem[wr_addr_i] <= wr_data_i;
    end
    if (rd_en_i) begin
      rd_data_q <= mem[rd_addr_i];
    end
  end

  // Track which entries hold real data since reset
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      written_q    <= '0;
      rd_written_q <= 1'b0;
    end else begin
      if (wr_en_i) begin
        written_q[wr_addr_i] <= 1'b1;
      end
      if (rd_en_i) begin
        rd_written_q <= written_q[rd_addr_i];
      end
    end
  end

  // Unwritten entries read as the reset value
  assign rd_data_o = rd_written_q ? rd_data_q : '0;

endmodule

// ===== design/lcrf_exec.sv =====
// ----------------------------------------------------------------------------
// lcrf_exec
// Execute unit: applies one operation to the entry read from memory and
// produces the updated entry and the transaction result.
// ----------------------------------------------------------------------------
module lcrf_exec #(
  parameter int unsigned WINDOW_BITS = 32
) (
  input  lcrf_pkg::lcrf_op_e                  op_i,
  input  logic                                in_range_i,
  input  logic                                key_valid_i,
  input  logic [lcrf_pkg::CTR_W-1:0]          frame_counter_i,
  input  logic [lcrf_pkg::LEN_W-1:0]          frame_length_i,
  input  logic [lcrf_pkg::LEN_W-1:0]          header_length_i,
  input  logic                                auth_passed_i,
  input  logic                                key_import_ok_i,
  input  logic [lcrf_pkg::WIN_W-1:0]          replay_window_i,
  input  logic [lcrf_pkg::TAG_W-1:0]          tag_length_i,
  input  logic [lcrf_pkg::LEN_W-1:0]          max_frame_length_i,
  input  logic [lcrf_pkg::LEN_W-1:0]          min_secure_length_i,
  input  logic [lcrf_pkg::CTR_W-1:0]          tx_count_i,
  input  logic [lcrf_pkg::CTR_W-1:0]          rx_highest_i,
  input  logic [WINDOW_BITS-1:0]              bitmap_i,
  output logic [lcrf_pkg::CTR_W-1:0]          tx_count_o,
  output logic [lcrf_pkg::CTR_W-1:0]          rx_highest_o,
  output logic [WINDOW_BITS-1:0]              bitmap_o,
  output lcrf_pkg::lcrf_ctl_t                 ctl_o
);

  import lcrf_pkg::*;

  localparam int unsigned SW = (WINDOW_BITS > 1) ? $clog2(WINDOW_BITS) : 1;

  logic [WIN_W:0]         win_eff;
  logic                   ahead;
  logic [CTR_W-1:0]       diff_up;
  logic [CTR_W-1:0]       behind;
  logic                   win_accept;
  logic [CTR_W-1:0]       win_rxh;
  logic [WINDOW_BITS-1:0] win_bm;
  logic [CTR_W-1:0]       tx_inc;
  logic [LEN_W:0]         tx_total;

  // Sliding replay window check
  always_comb begin
    win_eff = ({1'b0, replay_window_i} < (WIN_W+1)'(WINDOW_BITS)) ?
              {1'b0, replay_window_i} : (WIN_W+1)'(WINDOW_BITS);
    ahead   = frame_counter_i > rx_highest_i;
    diff_up = frame_counter_i - rx_highest_i;
    behind  = rx_highest_i - frame_counter_i;
    win_accept = 1'b0;
    win_rxh    = rx_highest_i;
    win_bm     = bitmap_i;
    if (frame_counter_i == '0) begin
      win_accept = 1'b0;
    end else if (ahead) begin
      win_accept = 1'b1;
      win_rxh    = frame_counter_i;
      if (diff_up >= CTR_W'(WINDOW_BITS)) begin
        win_bm = '0;
      end else begin
        win_bm = bitmap_i << diff_up[SW-1:0];
      end
      win_bm[0] = 1'b1;
    end else if (behind < CTR_W'(win_eff)) begin
      if (!bitmap_i[behind[SW-1:0]]) begin
        win_accept = 1'b1;
        win_bm[behind[SW-1:0]] = 1'b1;
      end
    end
  end

  assign tx_inc   = tx_count_i + CTR_W'(1);
  assign tx_total = {1'b0, frame_length_i} + (LEN_W+1)'(tag_length_i);

  // Decide the operation
  always_comb begin
    ctl_o        = '0;
    ctl_o.status = ST_OK;
    tx_count_o   = tx_count_i;
    rx_highest_o = rx_highest_i;
    bitmap_o     = bitmap_i;
    if (!in_range_i) begin
      ctl_o.status = ST_NO_KEY;
    end else begin
      unique case (op_i)
        OP_INSTALL: begin
          ctl_o.kv_we  = 1'b1;
          ctl_o.kv_val = key_import_ok_i;
          if (key_import_ok_i) begin
            ctl_o.ent_we = 1'b1;
            tx_count_o   = '0;
            rx_highest_o = '0;
            bitmap_o     = '0;
          end else begin
            ctl_o.status = ST_NO_KEY;
          end
        end
        OP_FORGET: begin
          ctl_o.kv_we  = 1'b1;
          ctl_o.kv_val = 1'b0;
        end
        OP_TX: begin
          if (!key_valid_i) begin
            ctl_o.status = ST_NO_KEY;
          end else if (frame_length_i < header_length_i) begin
            ctl_o.status = ST_BAD_LEN;
          end else begin
            // Counter stays consumed even when the size check fails
            ctl_o.ent_we   = 1'b1;
            tx_count_o     = tx_inc;
            ctl_o.assigned = tx_inc;
            if (tx_total > {1'b0, max_frame_length_i}) begin
              ctl_o.status = ST_TOO_BIG;
            end
          end
        end
        OP_RX: begin
          if (!key_valid_i) begin
            ctl_o.status = ST_NO_KEY;
          end else if (frame_length_i < min_secure_length_i) begin
            ctl_o.status = ST_BAD_LEN;
          end else if (!auth_passed_i) begin
            ctl_o.inc_auth = 1'b1;
            ctl_o.status   = ST_AUTH;
          end else if (!win_accept) begin
            ctl_o.inc_replay = 1'b1;
            ctl_o.status     = ST_REPLAY;
          end else begin
            ctl_o.ent_we = 1'b1;
            rx_highest_o = win_rxh;
            bitmap_o     = win_bm;
          end
        end
        default: begin
          ctl_o.status = ST_NO_KEY;
        end
      endcase
    end
  end

endmodule

// ===== design/link_counter_replay_filter.sv =====
// ----------------------------------------------------------------------------
// link_counter_replay_filter
// Per-neighbour link frame counter assignment and sliding-window anti-replay
// filter with global authentication-failure and replay-drop counters.
// ----------------------------------------------------------------------------
//  Channel   Direction  Handshake                  Content
//  s_axis    in         s_axis_tvalid/tready       one operation on one entry
//  m_axis    out        m_axis_tvalid/tready       status, counter, totals
//  cfg       in         cfg_valid_i/cfg_ready_o    register index and value
//
//  Each transaction first reads its entry from the state memory (registered
//  read), then writes the update back with the result.
//  The next transaction is taken in the cycle after the write-back, so reads
//  never overlap a pending write to the same entry.
//  Reset clears key flags and totals and loads configuration defaults at once;
//  no clearing pass is needed. A full, stalled output register holds S_EXEC.
// ----------------------------------------------------------------------------
module link_counter_replay_filter #(
  parameter int unsigned NEIGHBOURS  = 16,
  parameter int unsigned WINDOW_BITS = 32
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // cfg: register index and write data
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [lcrf_pkg::CFG_IX_W-1:0] cfg_index_i,
  input  logic [lcrf_pkg::CFG_D_W-1:0]  cfg_data_i,
  // s_axis_tuser: opcode [1:0]
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  input  logic [1:0]                    s_axis_tuser,
  // s_axis_tdata: neighbour_index [3:0], frame_counter [35:4],
  //   frame_length [43:36], header_length [51:44], auth_passed [52],
  //   key_import_ok [53], zero fill [55:54]
  input  logic [55:0]                   s_axis_tdata,
  // m_axis_tdata: status [2:0], assigned_counter [34:3],
  //   auth_failure_total [66:35], replay_drop_total [98:67], zero fill [103:99]
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  output logic [103:0]                  m_axis_tdata
);

  import lcrf_pkg::*;

  localparam int unsigned AW = (NEIGHBOURS > 1) ? $clog2(NEIGHBOURS) : 1;
  localparam int unsigned DW = 2 * CTR_W + WINDOW_BITS;

  // Configuration registers
  logic [WIN_W-1:0] replay_window_q;
  logic [TAG_W-1:0] tag_length_q;
  logic [LEN_W-1:0] max_frame_q;
  logic [LEN_W-1:0] min_secure_q;

  // Held transaction
  lcrf_state_e      state_q, state_d;
  lcrf_op_e         op_q;
  logic             in_range_q;
  logic [AW-1:0]    addr_q;
  logic [CTR_W-1:0] ctr_q;
  logic [LEN_W-1:0] flen_q;
  logic [LEN_W-1:0] hlen_q;
  logic             auth_q;
  logic             imp_q;

  logic [NEIGHBOURS-1:0] key_valid_q;
  logic [CTR_W-1:0]      auth_total_q;
  logic [CTR_W-1:0]      replay_total_q;

  logic                  m_valid_q;
  logic [103:0]          m_data_q;

  logic                  in_fire;
  logic                  exec_fire;
  logic [AW-1:0]         in_addr;
  logic [DW-1:0]         rd_data;
  logic [DW-1:0]         wr_data;
  logic [CTR_W-1:0]      tx_new;
  logic [CTR_W-1:0]      rxh_new;
  logic [WINDOW_BITS-1:0] bm_new;
  lcrf_ctl_t             ctl;
  logic [CTR_W-1:0]      auth_total_d;
  logic [CTR_W-1:0]      replay_total_d;

  assign cfg_ready_o   = 1'b1;
  assign s_axis_tready = (state_q == S_IDLE);
  assign in_fire       = s_axis_tvalid && s_axis_tready;
  assign exec_fire     = (state_q == S_EXEC) && (!m_valid_q || m_axis_tready);
  assign in_addr       = AW'(s_axis_tdata[3:0]);

  // Write configuration registers; unknown indexes are dropped
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      replay_window_q <= WIN_W'(32);
      tag_length_q    <= TAG_W'(8);
      max_frame_q     <= LEN_W'(127);
      min_secure_q    <= LEN_W'(12);
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        REG_REPLAY_WINDOW: replay_window_q <= cfg_data_i[WIN_W-1:0];
        REG_TAG_LENGTH:    tag_length_q    <= cfg_data_i[TAG_W-1:0];
        REG_MAX_FRAME:     max_frame_q     <= cfg_data_i;
        REG_MIN_SECURE:    min_secure_q    <= cfg_data_i;
        default: begin
        end
      endcase
    end
  end

  // Sequence: take a transaction, then execute and write back
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (in_fire) begin
          state_d = S_EXEC;
        end
      end
      S_EXEC: begin
        if (exec_fire) begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Capture the transaction payload
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      op_q       <= lcrf_op_e'(s_axis_tuser);
      in_range_q <= (32'(s_axis_tdata[3:0]) < NEIGHBOURS);
      addr_q     <= in_addr;
      ctr_q      <= s_axis_tdata[35:4];
      flen_q     <= s_axis_tdata[43:36];
      hlen_q     <= s_axis_tdata[51:44];
      auth_q     <= s_axis_tdata[52];
      imp_q      <= s_axis_tdata[53];
    end
  end

  lcrf_state_mem #(
    .DEPTH (NEIGHBOURS),
    .DW    (DW)
  ) u_mem (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .rd_en_i   (in_fire),
    .rd_addr_i (in_addr),
    .rd_data_o (rd_data),
    .wr_en_i   (exec_fire && ctl.ent_we),
    .wr_addr_i (addr_q),
    .wr_data_i (wr_data)
  );

  lcrf_exec #(
    .WINDOW_BITS (WINDOW_BITS)
  ) u_exec (
    .op_i                (op_q),
    .in_range_i          (in_range_q),
    .key_valid_i         (key_valid_q[addr_q]),
    .frame_counter_i     (ctr_q),
    .frame_length_i      (flen_q),
    .header_length_i     (hlen_q),
    .auth_passed_i       (auth_q),
    .key_import_ok_i     (imp_q),
    .replay_window_i     (replay_window_q),
    .tag_length_i        (tag_length_q),
    .max_frame_length_i  (max_frame_q),
    .min_secure_length_i (min_secure_q),
    .tx_count_i          (rd_data[CTR_W-1:0]),
    .rx_highest_i        (rd_data[2*CTR_W-1:CTR_W]),
    .bitmap_i            (rd_data[DW-1:2*CTR_W]),
    .tx_count_o          (tx_new),
    .rx_highest_o        (rxh_new),
    .bitmap_o            (bm_new),
    .ctl_o               (ctl)
  );

  assign wr_data        = {bm_new, rxh_new, tx_new};
  assign auth_total_d   = ctl.inc_auth ? auth_total_q + CTR_W'(1) : auth_total_q;
  assign replay_total_d = ctl.inc_replay ? replay_total_q + CTR_W'(1) : replay_total_q;

  // Commit key flags and global totals
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      key_valid_q    <= '0;
      auth_total_q   <= '0;
      replay_total_q <= '0;
    end else if (exec_fire) begin
      if (ctl.kv_we) begin
        key_valid_q[addr_q] <= ctl.kv_val;
      end
      auth_total_q   <= auth_total_d;
      replay_total_q <= replay_total_d;
    end
  end

  // Hold the result until the sink takes it
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_valid_q <= 1'b0;
    end else if (exec_fire) begin
      m_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      m_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (exec_fire) begin
      m_data_q <= {5'b0, replay_total_d, auth_total_d, ctl.assigned, ctl.status};
    end
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = m_data_q;

`include "link_counter_replay_filter_assert.svh"

  `LCRF_ASSERT_NEXT(a_accept_to_exec, in_fire, state_q == S_EXEC, "accepted transaction did not enter execute")
  `LCRF_ASSERT_NOW(a_write_in_exec, ctl.ent_we && exec_fire, state_q == S_EXEC, "entry write outside execute")
  `LCRF_ASSERT_NEXT(a_replay_count, exec_fire && ctl.inc_replay, replay_total_q == 32'($past(replay_total_q) + 32'd1), "replay total not advanced")
  `LCRF_ASSERT_NEXT(a_auth_hold, !exec_fire, $stable(auth_total_q), "auth failure total changed without a commit")

endmodule
